// File: hw/rtl/aol_pkg.sv
package aol_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND,
    MODE_REM_POS,
    MODE_REM_VAL,
    MODE_FIND,
    MODE_READ,
    MODE_CLEAR
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_RANGE,
    ST_MISSING
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } fsm_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [4:0]         position;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [4:0]         found_index;
    logic [5:0]         count;
  } out_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic cmp;
  } cell_ctl_t;

endpackage

// File: hw/rtl/aol_cell.sv
module aol_cell (
  input  logic                    clk_i,
  input  aol_pkg::cell_ctl_t      ctl_i,
  input  logic                    valid_i,
  input  logic signed [31:0]      key_i,
  input  logic signed [31:0]      nbr_i,
  output logic signed [31:0]      entry_o,
  output logic                    match_o
);
  import aol_pkg::*;

  logic signed [31:0] entry_q, entry_d;
  logic               match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = nbr_i;
    end else if (ctl_i.load) begin
      entry_d = key_i;
    end
    match_d = ctl_i.cmp ? (valid_i && (entry_q == key_i)) : match_q;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// File: hw/rtl/ordered_array_list_engine.sv
// Ordered list of signed 32-bit entries, CAPACITY deep, one cell per entry.
// Input channel in_valid_i/in_ready_o carries one beat per operation (mode,
// value, position); output channel out_valid_o/out_ready_i returns exactly
// one beat per operation (status, data, found_index, count).
// Operations: append, remove at position, remove first match of value,
// find first match of value, read at position, clear. Removal shifts all
// later cells down by one place at once.
// Append, remove at position, read and clear go from acceptance straight
// to the finish state. Find and remove value compare all cells in
// parallel, then a scan steps over the registered match flags one entry per
// cycle up to the first match, or to the end of the list when none matches.
// One operation is in flight at a time; the next beat is taken the cycle
// after the previous result is loaded into the output register.
// Reset empties the list; cell contents are not cleared.
// When the receiver stalls, the result waits in the output register; one
// further beat may be accepted and then holds until that register frees.
module ordered_array_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  aol_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output aol_pkg::out_t out_o
);
  import aol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > 5) ? CW : 5;

  fsm_e               state_q, state_d;
  in_t                op_q;
  logic [IW-1:0]      scan_q, scan_d;
  logic               hit_q, hit_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  logic [CW-1:0]      count_q, count_d, count_n;
  out_t               out_q, res;
  logic               out_valid_q, out_valid_d;

  logic               accept, fin_go, scan_end;
  logic               do_load, do_shift;
  logic [XW-1:0]      sidx, pos_x, cnt_x;
  logic signed [31:0] key, rd_data;
  logic signed [31:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0] match_w;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fin_go     = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign scan_end   = (CW'(scan_q) + CW'(1)) >= count_q;
  assign key        = accept ? in_i.value : op_q.value;
  assign pos_x      = XW'(op_q.position);
  assign cnt_x      = XW'(count_q);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t          ctl;
    logic signed [31:0] nbr;

    if (i == CAPACITY - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry_w[i+1];
    end

    assign ctl.cmp   = accept;
    assign ctl.load  = fin_go && do_load && (XW'(i) == cnt_x);
    assign ctl.shift = fin_go && do_shift && (XW'(i) >= sidx);

    aol_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .valid_i (XW'(i) < cnt_x),
      .key_i   (key),
      .nbr_i   (nbr),
      .entry_o (entry_w[i]),
      .match_o (match_w[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (XW'(i) == pos_x) begin
        rd_data = entry_w[i];
      end
    end
  end

  // sequencing
  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          scan_d    = '0;
          hit_d     = 1'b0;
          hit_idx_d = '0;
          if (in_i.mode == MODE_REM_VAL || in_i.mode == MODE_FIND) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (match_w[scan_q]) begin
          hit_d     = 1'b1;
          hit_idx_d = scan_q;
          state_d   = S_FIN;
        end else if (scan_end) begin
          state_d = S_FIN;
        end else begin
          scan_d = scan_q + IW'(1);
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // operation result
  always_comb begin
    res          = '0;
    res.status   = ST_OK;
    count_n      = count_q;
    do_load      = 1'b0;
    do_shift     = 1'b0;
    sidx         = pos_x;
    unique case (op_q.mode)
      MODE_APPEND: begin
        if (count_q == CW'(CAPACITY)) begin
          res.status = ST_FULL;
        end else begin
          do_load = 1'b1;
          count_n = count_q + CW'(1);
        end
      end
      MODE_REM_POS: begin
        if (pos_x >= cnt_x) begin
          res.status = ST_RANGE;
        end else begin
          do_shift = 1'b1;
          count_n  = count_q - CW'(1);
        end
      end
      MODE_REM_VAL: begin
        if (hit_q) begin
          res.found_index = 5'(hit_idx_q);
          sidx            = XW'(hit_idx_q);
          do_shift        = 1'b1;
          count_n         = count_q - CW'(1);
        end else begin
          res.status = ST_MISSING;
        end
      end
      MODE_FIND: begin
        if (hit_q) begin
          res.found_index = 5'(hit_idx_q);
        end else begin
          res.status = ST_MISSING;
        end
      end
      MODE_READ: begin
        if (pos_x >= cnt_x || pos_x >= XW'(CAPACITY)) begin
          res.status = ST_RANGE;
        end else begin
          res.data = rd_data;
        end
      end
      MODE_CLEAR: begin
        count_n = '0;
      end
      default: begin
        count_n = count_q;
      end
    endcase
    res.count   = 6'(count_n);
    count_d     = fin_go ? count_n : count_q;
    out_valid_d = fin_go ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    if (accept) begin
      op_q <= in_i;
    end
    if (fin_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
